// File: design/sar_precision_matrix_engine_unit_assert.svh
// Assertion macros shared by the precision matrix engine RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef SAR_PRECISION_MATRIX_ENGINE_UNIT_ASSERT_SVH
`define SAR_PRECISION_MATRIX_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SPM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define SPM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: design/spm_pkg.sv
// Shared types and constants for the precision matrix engine.
// No dependencies; used by spm_mac and the top level.
`timescale 1ns / 1ps

package spm_pkg;

  localparam int ROW_W      = 6;
  localparam int T_W        = 16;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int A_W        = 18;
  localparam int PROD_W     = 36;
  localparam int RES_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAU         = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd1;
  localparam logic [T_W-1:0]    TAU_RESET  = 16'd256;

  typedef struct packed {
    logic clear;
    logic valid;
    logic diag_a;
    logic diag_b;
    logic scale_lo;
    logic scale_hi;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic saturated;
  } mac_stat_t;

endpackage

// File: design/spm_mac.sv
// Shared multiply-accumulate unit: forms A-matrix terms, accumulates their
// products and applies the final tau scaling with saturation. Uses spm_pkg.
`timescale 1ns / 1ps

module spm_mac #(
  parameter int ACC_W = 42
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [spm_pkg::T_W-1:0]      rho,
  input  logic        [spm_pkg::T_W-1:0]      tau,
  input  logic signed [spm_pkg::T_W-1:0]      t_a,
  input  logic signed [spm_pkg::T_W-1:0]      t_b,
  input  spm_pkg::mac_cmd_t                   cmd,
  output spm_pkg::mac_stat_t                  stat,
  output logic signed [spm_pkg::RES_W-1:0]    result
);
  import spm_pkg::*;

  localparam int LO_W    = 22;
  localparam int HI_W    = ACC_W - LO_W;
  localparam int OP_W    = (HI_W > 23) ? HI_W : 23;
  localparam int OPB_W   = 18;
  localparam int MUL_W   = OP_W + OPB_W;
  localparam int LO_P_W  = LO_W + T_W;
  localparam int SUM_W   = MUL_W + 1;
  localparam int Q28_W   = 34;
  localparam int CARRY_W = LO_P_W + 1 - LO_W;

  localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] RES_MIN = SUM_W'(32'sh8000_0000);
  localparam logic signed [Q28_W-1:0] ONE_Q28 = Q28_W'(64'sd268435456);
  localparam logic signed [Q28_W-1:0] HALF_Q14 = Q28_W'(64'sd8192);
  localparam logic [LO_P_W:0]         HALF_LO = (LO_P_W+1)'(64'd2097152);

  // Stage 2: rho times weight.
  logic                     v2_r, da2_r, db2_r;
  logic signed [2*T_W-1:0]  pr_a_r, pr_b_r;
  // Stage 3: rounded A terms.
  logic                     v3_r;
  logic signed [A_W-1:0]    a_a_r, a_b_r;
  // Stage 4: shared multiplier output.
  logic                     m_acc_r, m_lo_r, m_hi_r;
  logic signed [MUL_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [LO_P_W-1:0]        lo_r;
  logic signed [RES_W-1:0]  res_r;
  logic                     sat_r, res_valid_r;

  logic signed [Q28_W-1:0]  q28_a, q28_b, rnd_a, rnd_b;
  logic signed [OP_W-1:0]   op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic [LO_P_W:0]          lo_rnd;
  logic [CARRY_W-1:0]       carry;
  logic signed [SUM_W-1:0]  res_full;

  always_comb begin
    q28_a = -Q28_W'(pr_a_r) + (da2_r ? ONE_Q28 : '0);
    q28_b = -Q28_W'(pr_b_r) + (db2_r ? ONE_Q28 : '0);
    rnd_a = (q28_a + HALF_Q14) >>> 14;
    rnd_b = (q28_b + HALF_Q14) >>> 14;
  end

  // Operand selection for the one multiplier.
  always_comb begin
    if (cmd.scale_lo) begin
      op_a = signed'(OP_W'(acc_r[LO_W-1:0]));
      op_b = signed'(OPB_W'(tau));
    end else if (cmd.scale_hi) begin
      op_a = OP_W'(signed'(acc_r[ACC_W-1:LO_W]));
      op_b = signed'(OPB_W'(tau));
    end else begin
      op_a = OP_W'(a_a_r);
      op_b = OPB_W'(a_b_r);
    end
  end

  // Final rounding: the low partial product only contributes its carry.
  always_comb begin
    lo_rnd   = {1'b0, lo_r} + HALF_LO;
    carry    = lo_rnd[LO_P_W:LO_W];
    res_full = SUM_W'(prod_r) + SUM_W'(signed'({1'b0, carry}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      m_acc_r     <= 1'b0;
      m_lo_r      <= 1'b0;
      m_hi_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      v2_r        <= cmd.valid;
      v3_r        <= v2_r;
      m_acc_r     <= v3_r;
      m_lo_r      <= cmd.scale_lo;
      m_hi_r      <= cmd.scale_hi;
      res_valid_r <= m_hi_r;
    end
    da2_r  <= cmd.diag_a;
    db2_r  <= cmd.diag_b;
    pr_a_r <= rho * t_a;
    pr_b_r <= rho * t_b;
    a_a_r  <= rnd_a[A_W-1:0];
    a_b_r  <= rnd_b[A_W-1:0];
    prod_r <= op_a * op_b;
    if (cmd.clear) begin
      acc_r <= '0;
    end else if (m_acc_r) begin
      acc_r <= acc_r + ACC_W'(signed'(prod_r[PROD_W-1:0]));
    end
    if (m_lo_r) begin
      lo_r <= prod_r[LO_P_W-1:0];
    end
    if (m_hi_r) begin
      if (res_full > RES_MAX) begin
        res_r <= RES_MAX[RES_W-1:0];
        sat_r <= 1'b1;
      end else if (res_full < RES_MIN) begin
        res_r <= RES_MIN[RES_W-1:0];
        sat_r <= 1'b1;
      end else begin
        res_r <= res_full[RES_W-1:0];
        sat_r <= 1'b0;
      end
    end
  end

  assign stat.busy      = v2_r | v3_r | m_acc_r;
  assign stat.res_valid = res_valid_r;
  assign stat.saturated = sat_r;
  assign result         = res_r;

endmodule

// File: design/sar_precision_matrix_engine_unit.sv
// Precision matrix engine top level: weight store, sequencer and output word.
// An in-range read word holds busy high while the sequencer runs through RUN, where the
// shared MAC walks one column pair per cycle, then DRAIN, SCALE_LO, SCALE_HI and WAIT,
// and its result word follows WAIT. A write word gives no result; a read outside
// the active size answers in the next cycle, and the receiver cannot stall.
// Synchronous reset clears control and config, not the store.
`timescale 1ns / 1ps
`include "sar_precision_matrix_engine_unit_assert.svh"

module sar_precision_matrix_engine_unit #(
  parameter int MAX_DIM = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [spm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_func,
  input  logic        [spm_pkg::ROW_W-1:0]      in_row,
  input  logic        [spm_pkg::ROW_W-1:0]      in_col,
  input  logic signed [spm_pkg::T_W-1:0]        in_t_value,
  output logic                                  out_valid,
  output logic signed [spm_pkg::RES_W-1:0]      out_prec_value,
  output logic                                  out_saturated
);
  import spm_pkg::*;

  // Index widths follow the store dimension. CMP_W is wide enough to hold
  // MAX_DIM itself, the 7-bit size register and the 6-bit index ports.
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  // Each product fits in PROD_W bits; one guard bit per doubling of terms.
  localparam int ACC_W  = PROD_W + IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_WAIT
  } state_t;

  // Configuration registers.
  logic        [SIZE_W-1:0] size_r;
  logic signed [T_W-1:0]    rho_r;
  logic        [T_W-1:0]    tau_r;

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic [CMP_W-1:0]   k_r, n_r;
  logic [IDX_W-1:0]   row_idx_r, col_idx_r;

  // Memory read stage, aligned with the registered read data.
  logic               s1_valid_r, s1_da_r, s1_db_r;
  logic signed [T_W-1:0] t_a_r, t_b_r;
  logic [T_W-1:0]     weight_mem [DEPTH];

  // Output word.
  logic                     out_valid_r, out_sat_r;
  logic signed [RES_W-1:0]  out_prec_r;

  logic [CMP_W-1:0]   row_ext, col_ext, size_ext, n_eff;
  logic               accept, wr_ok, mem_we, in_range, last_k;
  logic [IDX_W-1:0]   k_idx;
  logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;

  mac_cmd_t                mac_cmd;
  mac_stat_t               mac_stat;
  logic signed [RES_W-1:0] mac_result;

  // ---------------------------------------------------------------------
  // Input decode. The effective size is clamped to 1..MAX_DIM; a write
  // that falls outside the store is dropped, and a read outside the active
  // size answers zero without starting the walk.
  // ---------------------------------------------------------------------
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign row_ext  = CMP_W'(in_row);
  assign col_ext  = CMP_W'(in_col);
  assign size_ext = CMP_W'(size_r);

  always_comb begin
    if (size_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(MAX_DIM)) begin
      n_eff = CMP_W'(MAX_DIM);
    end else begin
      n_eff = size_ext;
    end
  end

  assign wr_ok    = (row_ext < CMP_W'(MAX_DIM)) && (col_ext < CMP_W'(MAX_DIM));
  assign mem_we   = accept && (in_func == FUNC_WRITE) && wr_ok;
  assign in_range = (row_ext < n_eff) && (col_ext < n_eff);
  assign wr_addr  = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};

  // The walk over k reads T(k,row) and T(k,col) in the same cycle through
  // the two read ports of the weight store.
  assign k_idx     = k_r[IDX_W-1:0];
  assign last_k    = (k_r == n_r - CMP_W'(1));
  assign rd_addr_a = {k_idx, row_idx_r};
  assign rd_addr_b = {k_idx, col_idx_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      weight_mem[wr_addr] <= in_t_value;
    end
    t_a_r <= signed'(weight_mem[rd_addr_a]);
    t_b_r <= signed'(weight_mem[rd_addr_b]);
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      rho_r  <= '0;
      tau_r  <= TAU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATRIX_SIZE: size_r <= cfg_data[SIZE_W-1:0];
        REG_RHO:         rho_r  <= signed'(cfg_data);
        REG_TAU:         tau_r  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer. RUN issues one k per cycle, DRAIN lets the MAC pipeline
  // empty, the two SCALE states feed the low and high halves of the sum
  // through the same multiplier with tau, and WAIT picks up the result.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_READ) && in_range) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_r && !mac_stat.busy) begin
          state_nxt = ST_SCALE_LO;
        end
      end
      ST_SCALE_LO: state_nxt = ST_SCALE_HI;
      ST_SCALE_HI: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mac_stat.res_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= (state_r == ST_RUN);
      out_valid_r <= 1'b0;
      if (accept && (in_func == FUNC_READ) && !in_range) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == ST_WAIT) && mac_stat.res_valid) begin
        out_valid_r <= 1'b1;
      end
    end
    s1_da_r <= (k_idx == row_idx_r);
    s1_db_r <= (k_idx == col_idx_r);
    if (state_r == ST_IDLE) begin
      k_r       <= '0;
      n_r       <= n_eff;
      row_idx_r <= row_ext[IDX_W-1:0];
      col_idx_r <= col_ext[IDX_W-1:0];
      out_prec_r <= '0;
      out_sat_r  <= 1'b0;
    end else if (state_r == ST_RUN) begin
      k_r <= k_r + CMP_W'(1);
    end
    if ((state_r == ST_WAIT) && mac_stat.res_valid) begin
      out_prec_r <= mac_result;
      out_sat_r  <= mac_stat.saturated;
    end
  end

  assign mac_cmd.clear    = accept && (in_func == FUNC_READ) && in_range;
  assign mac_cmd.valid    = s1_valid_r;
  assign mac_cmd.diag_a   = s1_da_r;
  assign mac_cmd.diag_b   = s1_db_r;
  assign mac_cmd.scale_lo = (state_r == ST_SCALE_LO);
  assign mac_cmd.scale_hi = (state_r == ST_SCALE_HI);

  spm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .rho    (rho_r),
    .tau    (tau_r),
    .t_a    (t_a_r),
    .t_b    (t_b_r),
    .cmd    (mac_cmd),
    .stat   (mac_stat),
    .result (mac_result)
  );

  assign out_valid      = out_valid_r;
  assign out_prec_value = out_prec_r;
  assign out_saturated  = out_sat_r;

  // An in-range read always starts the walk on the next cycle.
  `SPM_ASSERT_NEXT(a_read_starts, accept && (in_func == FUNC_READ) && in_range, state_r == ST_RUN)
  // The walk never steps past the active size.
  `SPM_ASSERT_IMPL(a_run_bound, state_r == ST_RUN, k_r < n_r)
  // Scaling starts only once every term has been accumulated.
  `SPM_ASSERT_IMPL(a_drained, state_r == ST_SCALE_LO, !s1_valid_r && !mac_stat.busy)
  // A MAC result appears only while the sequencer waits for it.
  `SPM_ASSERT_IMPL(a_res_in_wait, mac_stat.res_valid, state_r == ST_WAIT)
  // A clipped word sits on one of the two rails.
  `SPM_ASSERT_IMPL(a_sat_rail, out_valid && out_saturated, (out_prec_value == 32'sh7FFF_FFFF) || (out_prec_value == 32'sh8000_0000))

endmodule
